### rtl/ucdef_pkg.sv
// ----------------------------------------------------------------------------
// ucdef_pkg
// Shared types and constants for the bulk endpoint finder.
// ----------------------------------------------------------------------------
`default_nettype none

package ucdef_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned EpNumW = 4;
  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CLASS_MATCH_A = 2'd0,
    CFG_CLASS_MATCH_B = 2'd1
  } cfg_idx_e;

  localparam logic [ByteW-1:0] ClassMatchAReset = 8'hE0;
  localparam logic [ByteW-1:0] ClassMatchBReset = 8'hFF;

  localparam logic [ByteW-1:0] DescTypeInterface = 8'd4;
  localparam logic [ByteW-1:0] DescTypeEndpoint  = 8'd5;
  localparam logic [ByteW-1:0] IfDescMinLen      = 8'd9;
  localparam logic [ByteW-1:0] EpDescMinLen      = 8'd7;
  localparam logic [ByteW-1:0] DescMinLen        = 8'd2;

  localparam logic [ByteW-1:0] PosType    = 8'd1;
  localparam logic [ByteW-1:0] PosEpAddr  = 8'd2;
  localparam logic [ByteW-1:0] PosAttr    = 8'd3;
  localparam logic [ByteW-1:0] PosClass   = 8'd5;

  localparam logic [1:0] XferTypeBulk = 2'b10;

endpackage

`default_nettype wire

### rtl/usb_config_descriptor_endpoint_finder_core.sv
// ----------------------------------------------------------------------------
// usb_config_descriptor_endpoint_finder_core
// Walks a configuration descriptor set and reports bulk IN/OUT endpoints.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one descriptor byte per item in tdata, tlast on the final
//   byte of the set. m_axis gives one result item per set, after the byte
//   with tlast: tdata holds the IN and OUT endpoint numbers, tuser the found
//   flag (IN endpoint number nonzero).
//   The parser updates its state in the cycle a byte is accepted; the result
//   register is loaded at the edge that accepts the last byte, so the result
//   shows in the cycle after. One byte per cycle is taken while s_axis_tready
//   is high, set by the single parser state update per byte.
//   A stalled result register holds its item; non-last bytes are still taken
//   while it waits, and a last byte waits until the result slot frees or is
//   taken in the same cycle.
//   Reset clears the parser and the result slot and loads the class match
//   registers with 0xE0 and 0xFF. Class registers are written through cfg_*;
//   index 0 is class A, index 1 class B, other indexes are ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module usb_config_descriptor_endpoint_finder_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,

  input  wire logic                          cfg_we_i,
  input  wire logic [ucdef_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [ucdef_pkg::ByteW-1:0]   cfg_wdata_i,

  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [7:0]                    s_axis_tdata,   // [7:0] data_byte
  input  wire logic                          s_axis_tlast,

  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [7:0]                         m_axis_tdata,   // [3:0] in_endpoint,
                                                             // [7:4] out_endpoint
  output logic                               m_axis_tuser    // [0] found
);

  import ucdef_pkg::*;

  logic [ByteW-1:0]  class_a_q, class_b_q;
  logic [ByteW-1:0]  pos_q, pos_d;
  logic [ByteW-1:0]  len_q, len_d;
  logic [ByteW-1:0]  type_q, type_d;
  logic [ByteW-1:0]  ep_addr_q, ep_addr_d;
  logic [1:0]        attr_q, attr_d;
  logic [ByteW-1:0]  class_q, class_d;
  logic              armed_q, armed_d;
  logic              stopped_q, stopped_d;
  logic [EpNumW-1:0] in_num_q, in_num_d;
  logic [EpNumW-1:0] out_num_q, out_num_d;

  logic              out_valid_q;
  logic [EpNumW-1:0] res_in_q, res_out_q;

  logic              in_acc;
  logic [ByteW:0]    pos_next;
  logic              desc_done;

  assign s_axis_tready = !out_valid_q || m_axis_tready || !s_axis_tlast;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign pos_next      = {1'b0, pos_q} + {{ByteW{1'b0}}, 1'b1};

  always_comb begin
    pos_d     = pos_q;
    len_d     = len_q;
    type_d    = type_q;
    ep_addr_d = ep_addr_q;
    attr_d    = attr_q;
    class_d   = class_q;
    armed_d   = armed_q;
    stopped_d = stopped_q;
    in_num_d  = in_num_q;
    out_num_d = out_num_q;
    desc_done = 1'b0;
    if (!stopped_q) begin
      if (pos_q == '0) begin
        if (s_axis_tdata < DescMinLen) begin
          stopped_d = 1'b1;
        end else begin
          len_d = s_axis_tdata;
          pos_d = PosType;
        end
      end else begin
        case (pos_q)
          PosType:   type_d    = s_axis_tdata;
          PosEpAddr: ep_addr_d = s_axis_tdata;
          PosAttr:   attr_d    = s_axis_tdata[1:0];
          PosClass:  class_d   = s_axis_tdata;
          default:   ;
        endcase
        desc_done = pos_next >= {1'b0, len_q};
        pos_d     = desc_done ? '0 : pos_next[ByteW-1:0];
        if (desc_done) begin
          if (type_d == DescTypeInterface && len_q >= IfDescMinLen) begin
            armed_d = (class_d == class_a_q) || (class_d == class_b_q);
          end else if (type_d == DescTypeEndpoint && len_q >= EpDescMinLen && armed_q) begin
            if (attr_d == XferTypeBulk) begin
              if (ep_addr_d[ByteW-1]) begin
                in_num_d = ep_addr_d[EpNumW-1:0];
              end else begin
                out_num_d = ep_addr_d[EpNumW-1:0];
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      class_a_q <= ClassMatchAReset;
      class_b_q <= ClassMatchBReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CLASS_MATCH_A: class_a_q <= cfg_wdata_i;
        CFG_CLASS_MATCH_B: class_b_q <= cfg_wdata_i;
        default:           ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      len_q     <= '0;
      type_q    <= '0;
      ep_addr_q <= '0;
      attr_q    <= '0;
      class_q   <= '0;
      armed_q   <= 1'b0;
      stopped_q <= 1'b0;
      in_num_q  <= '0;
      out_num_q <= '0;
    end else if (in_acc) begin
      if (s_axis_tlast) begin
        pos_q     <= '0;
        len_q     <= '0;
        type_q    <= '0;
        ep_addr_q <= '0;
        attr_q    <= '0;
        class_q   <= '0;
        armed_q   <= 1'b0;
        stopped_q <= 1'b0;
        in_num_q  <= '0;
        out_num_q <= '0;
      end else begin
        pos_q     <= pos_d;
        len_q     <= len_d;
        type_q    <= type_d;
        ep_addr_q <= ep_addr_d;
        attr_q    <= attr_d;
        class_q   <= class_d;
        armed_q   <= armed_d;
        stopped_q <= stopped_d;
        in_num_q  <= in_num_d;
        out_num_q <= out_num_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc && s_axis_tlast) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && s_axis_tlast) begin
      res_in_q  <= in_num_d;
      res_out_q <= out_num_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {res_out_q, res_in_q};
  assign m_axis_tuser  = res_in_q != '0;

`ifndef SYNTHESIS
  a_result_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_acc && s_axis_tlast))
    else $error("result appeared without a last byte");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tlast) |=> (pos_q == '0 && !armed_q && !stopped_q
                                  && in_num_q == '0 && out_num_q == '0))
    else $error("parser not cleared after last byte");

  a_stopped_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stopped_q |-> pos_q == '0)
    else $error("stopped parser holds a byte position");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |=> out_valid_q && $stable(res_in_q)
                                        && $stable(res_out_q))
    else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire
